// ===== sv/grd_pkg.sv =====
// shared types, constants and helpers for the golomb-rice delta decoder
// no dependencies; every other file imports this package
package grd_pkg;

	localparam int MAX_REMAINDER_BITS = 32;
	localparam int ACC_W = MAX_REMAINDER_BITS;
	localparam int WID_W = 6;
	localparam int SUM_W = 64;
	localparam int COUNT_W = 32;
	localparam int BYTE_W = 8;
	localparam int LEFT_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [WID_W-1:0] REMAINDER_BITS_RESET = WID_W'(19);

	typedef enum logic [1:0] {
		KIND_VALUE     = 2'd0,
		KIND_END_OK    = 2'd1,
		KIND_END_SHORT = 2'd2
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REMAINDER_BITS = 1'b0,
		CFG_ELEMENT_TOTAL  = 1'b1
	} cfg_reg_t;

	// one decoded code or end marker, front to back
	typedef struct packed {
		kind_t              kind;
		logic [SUM_W-1:0]   quot;
		logic [ACC_W-1:0]   acc;
		logic [WID_W-1:0]   rwidth;
		logic               run_last;
	} ev_t;

	// ones in the low n bit positions, n from 0 to 8
	function automatic logic [BYTE_W-1:0] lowmask(input logic [LEFT_W-1:0] n);
		logic [BYTE_W:0] t;
		t = ((BYTE_W+1)'(1) << n) - (BYTE_W+1)'(1);
		return t[BYTE_W-1:0];
	endfunction

	// position of the highest set bit, zero for an empty vector
	function automatic logic [2:0] hi_bit(input logic [BYTE_W-1:0] v);
		logic [2:0] p;
		p = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (v[i]) p = 3'(i);
		end
		return p;
	endfunction

endpackage

// ===== sv/grd_if.sv =====
// valid/ready channel interfaces for coded bytes in and decoded words out
// depends on grd_pkg
interface grd_in_if;
	logic                      valid;
	logic                      ready;
	logic [grd_pkg::BYTE_W-1:0] data_byte;
	logic                      last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface grd_out_if import grd_pkg::*;;
	logic             valid;
	logic             ready;
	kind_t            kind;
	logic [SUM_W-1:0] value;
	logic             run_last;

	modport source(output valid, kind, value, run_last, input ready);
	modport sink(input valid, kind, value, run_last, output ready);
endinterface

// ===== sv/grd_front.sv =====
// front end: byte register, bit parser and configuration registers
// depends on grd_pkg and grd_in_if; one word per cycle to a non-full queue
module grd_front import grd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	grd_in_if.sink                 coded,
	output logic                   push,
	output ev_t                    ev,
	input  logic                   q_not_full
);

	logic [WID_W-1:0]   rbits_q;
	logic [COUNT_W-1:0] total_q;

	logic               busy_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               last_q;
	logic [LEFT_W-1:0]  left_q;

	logic               in_rem_q;
	logic [SUM_W-1:0]   quot_q;
	logic [ACC_W-1:0]   acc_q;
	logic [WID_W-1:0]   taken_q;
	logic [COUNT_W-1:0] dec_q;

	logic [WID_W-1:0]   w;
	logic               ign;
	logic [BYTE_W-1:0]  zeros_av;
	logic               has_zero;
	logic [2:0]         z;
	logic [LEFT_W-1:0]  ones_u;
	logic [LEFT_W-1:0]  q_add;
	logic [SUM_W-1:0]   q_run;
	logic [LEFT_W-1:0]  top;
	logic [ACC_W-1:0]   acc_base;
	logic [WID_W-1:0]   taken_base;
	logic [WID_W-1:0]   need;
	logic               rem_phase;
	logic               hit;
	logic [LEFT_W-1:0]  n;
	logic [LEFT_W-1:0]  lo;
	logic [BYTE_W-1:0]  field;
	logic [ACC_W-1:0]   acc_new;
	logic [WID_W-1:0]   taken_new;
	logic [BYTE_W-1:0]  tzeros;
	logic               t_has;
	logic [2:0]         tz;
	logic [LEFT_W-1:0]  t_ones;
	logic [BYTE_W-1:0]  t_acc;
	logic [LEFT_W-1:0]  w8;
	logic               more;
	logic               cnt_room;
	logic               finish;
	logic               step;

	assign w = (rbits_q > WID_W'(MAX_REMAINDER_BITS)) ? WID_W'(MAX_REMAINDER_BITS) : rbits_q;
	assign ign = (dec_q >= total_q);

	always_comb begin
		zeros_av   = ~byte_q & lowmask(left_q);
		has_zero   = |zeros_av;
		z          = hi_bit(zeros_av);
		ones_u     = left_q - LEFT_W'(1) - {1'b0, z};
		q_add      = has_zero ? ones_u : left_q;
		q_run      = in_rem_q ? quot_q : quot_q + SUM_W'(q_add);

		// remainder bits start below the terminating zero or at the next bit
		top        = in_rem_q ? left_q : {1'b0, z};
		acc_base   = in_rem_q ? acc_q : '0;
		taken_base = in_rem_q ? taken_q : '0;
		if (in_rem_q) begin
			need = (w > taken_q) ? (w - taken_q) : WID_W'(1);
		end else begin
			need = w;
		end
		rem_phase  = in_rem_q || has_zero;
		hit        = !ign && rem_phase && ({2'b00, top} >= need);
		n          = hit ? need[LEFT_W-1:0] : top;
		lo         = top - n;
		field      = (byte_q >> lo) & lowmask(n);
		acc_new    = (acc_base << n) | ACC_W'(field);
		taken_new  = taken_base + WID_W'(n);

		// what the bits below a finished code leave behind
		tzeros     = ~byte_q & lowmask(lo);
		t_has      = |tzeros;
		tz         = hi_bit(tzeros);
		t_ones     = lo - LEFT_W'(1) - {1'b0, tz};
		t_acc      = byte_q & lowmask({1'b0, tz});
		w8         = (w > WID_W'(BYTE_W)) ? LEFT_W'(BYTE_W) : w[LEFT_W-1:0];
		cnt_room   = ({1'b0, dec_q} + (COUNT_W+1)'(1)) < {1'b0, total_q};
		more       = cnt_room && |(tzeros & ~lowmask(w8));

		finish     = !hit || (!more && !last_q);
		push       = busy_q && (hit || last_q);
		step       = busy_q && (!push || q_not_full);

		ev.quot     = q_run;
		ev.acc      = acc_new;
		ev.rwidth   = w;
		if (hit) begin
			ev.kind     = KIND_VALUE;
			ev.run_last = !more && !last_q;
		end else begin
			ev.kind     = (dec_q < total_q) ? KIND_END_SHORT : KIND_END_OK;
			ev.run_last = 1'b1;
		end
	end

	assign coded.ready = !busy_q || (step && finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbits_q  <= REMAINDER_BITS_RESET;
			total_q  <= '0;
			busy_q   <= 1'b0;
			last_q   <= 1'b0;
			left_q   <= '0;
			in_rem_q <= 1'b0;
			quot_q   <= '0;
			acc_q    <= '0;
			taken_q  <= '0;
			dec_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REMAINDER_BITS: rbits_q <= cfg_data[WID_W-1:0];
					CFG_ELEMENT_TOTAL:  total_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (step) begin
				if (hit) begin
					dec_q <= dec_q + COUNT_W'(1);
					if (more || !cnt_room) begin
						in_rem_q <= 1'b0;
						quot_q   <= '0;
						acc_q    <= '0;
						taken_q  <= '0;
					end else if (t_has) begin
						in_rem_q <= 1'b1;
						quot_q   <= SUM_W'(t_ones);
						acc_q    <= ACC_W'(t_acc);
						taken_q  <= WID_W'(tz);
					end else begin
						in_rem_q <= 1'b0;
						quot_q   <= SUM_W'(lo);
						acc_q    <= '0;
						taken_q  <= '0;
					end
					left_q <= more ? lo : '0;
				end else begin
					if (!ign) begin
						if (rem_phase) begin
							in_rem_q <= 1'b1;
							acc_q    <= acc_new;
							taken_q  <= taken_new;
						end
						quot_q <= q_run;
					end
					left_q <= '0;
					// end of stream clears the decode state
					if (last_q) begin
						in_rem_q <= 1'b0;
						quot_q   <= '0;
						acc_q    <= '0;
						taken_q  <= '0;
						dec_q    <= '0;
					end
				end
			end
			if (coded.valid && coded.ready) begin
				busy_q <= 1'b1;
				last_q <= coded.last_byte;
				left_q <= LEFT_W'(BYTE_W);
			end else if (step && finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (coded.valid && coded.ready) begin
			byte_q <= coded.data_byte;
		end
	end

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_not_full |=> busy_q && $stable(left_q) && $stable(dec_q))
		else $error("byte advanced while the queue was full");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && push && ev.kind != KIND_VALUE |=> dec_q == '0 && !in_rem_q && quot_q == '0)
		else $error("end word did not clear the decode state");

endmodule

// ===== sv/grd_queue.sv =====
// short word queue between the parser and the summing stage
// depends on grd_pkg
module grd_queue import grd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ev_t  din,
	output logic not_full,
	input  logic pop,
	output ev_t  dout,
	output logic not_empty
);

	ev_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign not_full  = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH) &&
		(cnt_q == (QPTR_W+1)'(QUEUE_DEPTH)) == (wr_ptr_q == rd_ptr_q && cnt_q != '0))
		else $error("queue count out of step with pointers");

endmodule

// ===== sv/grd_back.sv =====
// back end: delta build, running sum and the output register
// depends on grd_pkg and grd_out_if
module grd_back import grd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ev_t      head,
	input  logic     not_empty,
	output logic     pop,
	grd_out_if.source result
);

	logic [SUM_W-1:0] sum_q;
	logic             ov_q;
	kind_t            kind_q;
	logic [SUM_W-1:0] value_q;
	logic             rl_q;
	logic [SUM_W-1:0] delta;
	logic [SUM_W-1:0] sum_next;

	// quotient above the remainder field, wrapping at 64 bits
	assign delta    = (head.quot << head.rwidth) | SUM_W'(head.acc);
	assign sum_next = sum_q + delta;
	assign pop      = not_empty && (!ov_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (pop) begin
				ov_q  <= 1'b1;
				sum_q <= (head.kind == KIND_VALUE) ? sum_next : '0;
			end else if (result.ready) begin
				ov_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.kind;
			value_q <= (head.kind == KIND_VALUE) ? sum_next : '0;
			rl_q    <= head.run_last;
		end
	end

	assign result.valid    = ov_q;
	assign result.kind     = kind_q;
	assign result.value    = value_q;
	assign result.run_last = rl_q;

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != KIND_VALUE |-> result.value == '0 && result.run_last)
		else $error("end word carries a value or is not run-last");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.kind != KIND_VALUE |=> sum_q == '0)
		else $error("running sum kept after end word");

endmodule

// ===== sv/golomb_rice_delta_decoder_unit.sv =====
// channel   | dir  | payload                              | handshake
// coded     | in   | data_byte[7:0], last_byte            | valid/ready
// result    | out  | kind[1:0], value[63:0], run_last     | valid/ready
// cfg       | in   | cfg_index[0], cfg_data[31:0]         | cfg_we, no stall
//
// a byte stays in the parser until every value it ends has been pushed, and the
// last byte until the end word too; the parser stalls while the queue is full
// it resolves at most one code per cycle; results leave at one word per cycle
// while ready; a four-word queue lets the parser run ahead while results wait
// arst_n clears control state; remainder_bits resets to 19, element_total to 0
module golomb_rice_delta_decoder_unit import grd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	grd_in_if.sink                 coded,
	grd_out_if.source              result
);

	logic push;
	ev_t  ev;
	logic q_not_full;
	logic pop;
	ev_t  head;
	logic q_not_empty;

	grd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.coded      (coded),
		.push       (push),
		.ev         (ev),
		.q_not_full (q_not_full)
	);

	grd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (ev),
		.not_full  (q_not_full),
		.pop       (pop),
		.dout      (head),
		.not_empty (q_not_empty)
	);

	grd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (q_not_empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
